// File: design/tevq_pkg.sv
// Package for the timed event queue: transaction types, status and request codes.
// No dependencies; used by tevq_cell and timed_event_queue_top.
package tevq_pkg;

    // Request codes carried in req_type
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // Fixed field widths of the transactions
    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Input transaction
    typedef struct packed {
        logic                     req_type;
        logic signed [TIME_W-1:0] event_time;
        logic        [TAG_W-1:0]  action_tag;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        t_status                  status;
        logic signed [TIME_W-1:0] out_time;
        logic        [TAG_W-1:0]  out_tag;
    } t_out_item;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins_en;
        logic                     pop_en;
        logic signed [TIME_W-1:0] new_time;
        logic        [TAG_W-1:0]  new_tag;
    } t_cell_cmd;

endpackage

// File: design/tevq_cell.sv
// One slot of the sorted shift-register queue: holds an entry and trades it
// with its neighbors on insert and pop. Depends on tevq_pkg.
module tevq_cell #(
    parameter int TB = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tevq_pkg::t_cell_cmd                i_cmd,
    input  logic                               i_left_goes,
    input  logic                               i_left_valid,
    input  logic signed [tevq_pkg::TIME_W-1:0] i_left_time,
    input  logic        [TB-1:0]               i_left_tag,
    input  logic                               i_right_valid,
    input  logic signed [tevq_pkg::TIME_W-1:0] i_right_time,
    input  logic        [TB-1:0]               i_right_tag,
    output logic                               o_goes,
    output logic                               o_valid,
    output logic signed [tevq_pkg::TIME_W-1:0] o_time,
    output logic        [TB-1:0]               o_tag
);
    import tevq_pkg::*;

    logic                     r_valid, n_valid;
    logic signed [TIME_W-1:0] r_time, n_time;
    logic        [TB-1:0]     r_tag, n_tag;

    // New entry belongs at or before this slot: slot empty or holds a later time
    assign o_goes = !r_valid || (r_time > i_cmd.new_time);

    // Next slot contents
    always_comb begin
        n_valid = r_valid;
        n_time  = r_time;
        n_tag   = r_tag;
        if (i_cmd.ins_en) begin
            if (i_left_goes) begin
                n_valid = i_left_valid;
                n_time  = i_left_time;
                n_tag   = i_left_tag;
            end else if (o_goes) begin
                n_valid = 1'b1;
                n_time  = i_cmd.new_time;
                n_tag   = i_cmd.new_tag[TB-1:0];
            end
        end else if (i_cmd.pop_en) begin
            n_valid = i_right_valid;
            n_time  = i_right_time;
            n_tag   = i_right_tag;
        end
    end

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry payload
    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_tag  <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_time  = r_time;
    assign o_tag   = r_tag;

endmodule

// File: design/timed_event_queue_top.sv
// Timed event queue top: a chain of tevq_cell slots kept in time order,
// plus the output register. Depends on tevq_pkg and tevq_cell.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
//  out     | o_out_valid | i_out_stall | o_out_data (t_out_item)
//
// One transaction per cycle unless stalled: every cell compares its time with
// the new one at once, so insert and pop each finish in the cycle accepted.
// The result enters the output register in the cycle after acceptance.
// Input is stalled only while a result sits in the output register and the
// output is stalled. Reset clears the occupancy flags at once; no clearing pass.
module timed_event_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tevq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tevq_pkg::t_out_item o_out_data
);
    import tevq_pkg::*;

    // Stored tag width: the input field carries 16 bits at most
    localparam int TB = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_head_valid;
    t_cell_cmd                w_cmd;
    logic                     w_goes  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   w_valid;
    logic signed [TIME_W-1:0] w_time  [QUEUE_DEPTH];
    logic        [TB-1:0]     w_tag   [QUEUE_DEPTH];

    logic      r_out_valid;
    t_out_item r_out_data, n_out_data;

    // Handshake
    assign o_in_stall   = r_out_valid && i_out_stall;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_full       = w_valid[QUEUE_DEPTH-1];
    assign w_head_valid = w_valid[0];

    // Command to the chain
    always_comb begin
        w_cmd.ins_en   = w_accept && (i_in_data.req_type == REQ_INSERT) && !w_full;
        w_cmd.pop_en   = w_accept && (i_in_data.req_type == REQ_POP) && w_head_valid;
        w_cmd.new_time = i_in_data.event_time;
        w_cmd.new_tag  = i_in_data.action_tag;
    end

    // Chain of slots, head at index 0
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic                     l_goes, l_valid, r_valid_in;
        logic signed [TIME_W-1:0] l_time, r_time_in;
        logic        [TB-1:0]     l_tag, r_tag_in;

        if (gi == 0) begin : g_head
            assign l_goes  = 1'b0;
            assign l_valid = 1'b0;
            assign l_time  = '0;
            assign l_tag   = '0;
        end else begin : g_mid
            assign l_goes  = w_goes[gi-1];
            assign l_valid = w_valid[gi-1];
            assign l_time  = w_time[gi-1];
            assign l_tag   = w_tag[gi-1];
        end

        if (gi == QUEUE_DEPTH-1) begin : g_tail
            assign r_valid_in = 1'b0;
            assign r_time_in  = '0;
            assign r_tag_in   = '0;
        end else begin : g_body
            assign r_valid_in = w_valid[gi+1];
            assign r_time_in  = w_time[gi+1];
            assign r_tag_in   = w_tag[gi+1];
        end

        tevq_cell #(
            .TB (TB)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_goes   (l_goes),
            .i_left_valid  (l_valid),
            .i_left_time   (l_time),
            .i_left_tag    (l_tag),
            .i_right_valid (r_valid_in),
            .i_right_time  (r_time_in),
            .i_right_tag   (r_tag_in),
            .o_goes        (w_goes[gi]),
            .o_valid       (w_valid[gi]),
            .o_time        (w_time[gi]),
            .o_tag         (w_tag[gi])
        );
    end

    // Result of the accepted transaction
    always_comb begin
        n_out_data.out_time = '0;
        n_out_data.out_tag  = '0;
        if (i_in_data.req_type == REQ_INSERT) begin
            n_out_data.status = w_full ? ST_FULL : ST_INSERTED;
        end else if (w_head_valid) begin
            n_out_data.status   = ST_POPPED;
            n_out_data.out_time = w_time[0];
            n_out_data.out_tag  = TAG_W'(w_tag[0]);
        end else begin
            n_out_data.status = ST_EMPTY;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Occupied slots always form a run from the head
    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("queue occupancy has a hole");

    // Head never later than the next entry
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[1] |-> !(w_time[0] > w_time[1]))
        else $error("queue head out of time order");

    // Insert into a full queue reports full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.req_type == REQ_INSERT && w_full)
        |=> (o_out_valid && o_out_data.status == ST_FULL))
        else $error("full insert not reported");

    // Pop on an empty queue reports empty with zero payload
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.req_type == REQ_POP && !w_head_valid)
        |=> (o_out_valid && o_out_data.status == ST_EMPTY
             && o_out_data.out_time == '0 && o_out_data.out_tag == '0))
        else $error("empty pop not reported");

endmodule
